// ===== rtl/ppse_pkg.sv =====
// Package: shared types, widths and mask/index helpers for the polar partial-sum encoder.
`default_nettype none

package ppse_pkg;

  localparam int TREE_W  = 63;
  localparam int UPPER_W = 31;
  localparam int CW_W    = 32;

  typedef logic [TREE_W-1:0] tree_t;

  // Positions whose level is encoded at this layer: bit l of p clear, l below level k.
  function automatic tree_t layer_mask(input int log_len, input int l);
    tree_t m;
    int    base;
    int    n;
    m = '0;
    for (int k = 1; k <= log_len; k++) begin
      n    = 1 << k;
      base = n - 1;
      if (l < k && base + n <= TREE_W) begin
        for (int p = 0; p < n; p++) begin
          if (((p >> l) & 1) == 0) m[base+p] = 1'b1;
        end
      end
    end
    return m;
  endfunction

  // Source bit for result bit i after reversing positions within its level.
  function automatic int rev_src(input int log_len, input int i);
    int src;
    int base;
    int n;
    int p;
    int q;
    src = i;
    for (int k = 1; k <= log_len; k++) begin
      n    = 1 << k;
      base = n - 1;
      if (base + n <= TREE_W && i >= base && i < base + n) begin
        p = i - base;
        q = 0;
        for (int b = 0; b < k; b++) q = q | (((p >> b) & 1) << (k - 1 - b));
        src = base + q;
      end
    end
    return src;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/polar_partial_sum_encoder_top.sv =====
// Polar partial-sum encoder for one list path: pipelined XOR butterfly plus bit reversal.
//
// Input channel (in_valid / in_stall) carries one path's decision tree per item.
// Output channel (out_valid / out_stall) returns the encoded, level-wise bit-reversed
// tree split into upper_levels (levels below the last) and codeword_bits (last level).
// An item moves on a rising edge where valid is high and stall is low.
//
// Pipeline: one input register, one register per butterfly layer (LOG_BLOCK_LEN of
// them) and one register after the bit reversal, so an accepted item passes through
// all of these registers in that order before it can be taken from the output. A new
// item is taken every cycle while nothing stalls; throughput is one item per cycle.
//
// When the receiver stalls, the last stage holds its item and bubbles ahead of it
// are squeezed out; in_stall rises only once every stage holds an item.
// Reset (rst, synchronous) clears all stage valid bits; payload registers keep
// whatever they held. Nothing else is stored between items.
`default_nettype none

module polar_partial_sum_encoder_top
  import ppse_pkg::*;
#(
  parameter int BLOCK_LEN     = 32,
  parameter int LOG_BLOCK_LEN = 5
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output      logic                in_stall,
  input  wire logic [TREE_W-1:0]   decision_tree,
  output      logic                out_valid,
  input  wire logic                out_stall,
  output      logic [UPPER_W-1:0]  upper_levels,
  output      logic [CW_W-1:0]     codeword_bits
);

  localparam int STAGES = LOG_BLOCK_LEN + 2;
  localparam int LAST   = STAGES - 1;

  tree_t                          data [STAGES];
  logic [STAGES-1:0]              vld;
  logic [STAGES-1:0]              adv;
  logic [STAGES-1:0][TREE_W-1:0]  stage_next;
  tree_t                          masked;
  tree_t                          reversed;

  // A stage may load when it is empty or its item moves on.
  always_comb begin
    adv[LAST] = !vld[LAST] || !out_stall;
    for (int s = LAST - 1; s >= 0; s--) adv[s] = !vld[s] || adv[s+1];
  end

  assign in_stall = !adv[0];

  // Drop tree bits beyond the 2*BLOCK_LEN-1 used positions.
  always_comb begin
    for (int i = 0; i < TREE_W; i++) begin
      masked[i] = (i < 2 * BLOCK_LEN - 1) ? decision_tree[i] : 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= in_valid;
      for (int s = 1; s < STAGES; s++) begin
        if (adv[s]) vld[s] <= vld[s-1];
      end
    end
  end

  assign stage_next[0] = masked;

  // One butterfly layer per stage, applied to every level at once.
  for (genvar s = 1; s <= LOG_BLOCK_LEN; s++) begin : g_layer
    localparam tree_t LMASK = layer_mask(LOG_BLOCK_LEN, s - 1);
    assign stage_next[s] = data[s-1] ^ ((data[s-1] >> (1 << (s - 1))) & LMASK);
  end

  for (genvar i = 0; i < TREE_W; i++) begin : g_rev
    localparam int SRC = rev_src(LOG_BLOCK_LEN, i);
    assign reversed[i] = data[LOG_BLOCK_LEN][SRC];
  end

  assign stage_next[LAST] = reversed;

  always_ff @(posedge clk) begin
    for (int s = 0; s < STAGES; s++) begin
      if (adv[s]) data[s] <= stage_next[s];
    end
  end

  assign out_valid = vld[LAST];

  always_comb begin
    for (int i = 0; i < UPPER_W; i++) begin
      upper_levels[i] = (i < BLOCK_LEN - 1) ? data[LAST][i] : 1'b0;
    end
    for (int i = 0; i < CW_W; i++) begin
      codeword_bits[i] = (i < BLOCK_LEN) ? data[LAST][BLOCK_LEN-1+i] : 1'b0;
    end
  end

  a_reset_empties: assert property (@(posedge clk) rst |=> (vld == '0))
    else $error("pipeline not empty after reset");

  a_accept_fills_first: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> vld[0])
    else $error("accepted item missing from first stage");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> ((&vld) && out_stall))
    else $error("input stalled while pipeline has a free slot");

  a_held_item_stays: assert property (@(posedge clk) disable iff (rst)
    (vld[LAST] && out_stall) |=> (vld[LAST] && $stable(data[LAST])))
    else $error("stalled output item changed or vanished");

endmodule

`default_nettype wire

// ===== dv/ppse_tb_pkg.sv =====
// Scoreboard for the polar partial-sum encoder: per-path prediction and result checks.
`timescale 1ns / 1ps

package ppse_tb_pkg;
  import ppse_pkg::*;

  localparam int LOG_LEN = 5;

  typedef struct packed {
    logic [UPPER_W-1:0] upper;
    logic [CW_W-1:0]    codeword;
  } partial_sums_t;

  // Encode each level with the polar butterfly, then reverse positions within the level.
  function automatic partial_sums_t predict_partial_sums(input tree_t tree);
    tree_t         t;
    logic [31:0]   v;
    logic [31:0]   r;
    int            n;
    int            base;
    int            q;
    partial_sums_t s;
    t = tree;
    for (int k = 1; k <= LOG_LEN; k++) begin
      n    = 1 << k;
      base = n - 1;
      v    = '0;
      for (int p = 0; p < n; p++) v[p] = t[base+p];
      // bits with layer bit set are never written in that layer, so in-place is safe
      for (int l = 0; l < k; l++) begin
        for (int p = 0; p < n; p++) begin
          if (((p >> l) & 1) == 0) v[p] = v[p] ^ v[p+(1<<l)];
        end
      end
      r = '0;
      for (int p = 0; p < n; p++) begin
        q = 0;
        for (int b = 0; b < k; b++) begin
          if (((p >> b) & 1) != 0) q = q | (1 << (k - 1 - b));
        end
        r[p] = v[q];
      end
      for (int p = 0; p < n; p++) t[base+p] = r[p];
    end
    s.upper    = t[UPPER_W-1:0];
    s.codeword = t[TREE_W-1:UPPER_W];
    return s;
  endfunction

  class partial_sum_scoreboard;
    partial_sums_t expected_sums[$];
    int            mismatches;
    int            paths_in;
    int            sums_checked;

    function new();
      mismatches   = 0;
      paths_in     = 0;
      sums_checked = 0;
    endfunction

    function int pending();
      return expected_sums.size();
    endfunction

    task report_mismatch(input string what);
      $display("MISMATCH at result %0d: %s", sums_checked, what);
      mismatches++;
    endtask

    function void note_path(input tree_t tree);
      expected_sums.push_back(predict_partial_sums(tree));
      paths_in++;
    endfunction

    task check_sums(input logic [UPPER_W-1:0] upper, input logic [CW_W-1:0] codeword);
      partial_sums_t exp_s;
      if (expected_sums.size() == 0) begin
        report_mismatch($sformatf("unexpected result upper=%h codeword=%h", upper, codeword));
      end else begin
        exp_s = expected_sums.pop_front();
        if (upper !== exp_s.upper)
          report_mismatch($sformatf("upper_levels %h, expected %h", upper, exp_s.upper));
        if (codeword !== exp_s.codeword)
          report_mismatch($sformatf("codeword_bits %h, expected %h", codeword,
                                    exp_s.codeword));
      end
      sums_checked++;
    endtask
  endclass

endpackage

// ===== dv/tb.sv =====
// Top-level testbench for polar_partial_sum_encoder_top: stimulus, flow control and checks.
`timescale 1ns / 1ps

module tb;
  import ppse_pkg::*;
  import ppse_tb_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 160;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [TREE_W-1:0]  decision_tree;
  logic               out_valid;
  logic               out_stall;
  logic [UPPER_W-1:0] upper_levels;
  logic [CW_W-1:0]    codeword_bits;

  partial_sum_scoreboard sums_sb;
  int                    cycles;
  bit                    hold_req;
  bit                    quiet;
  int                    holds_done;
  int                    sender_calm;

  polar_partial_sum_encoder_top dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .decision_tree(decision_tree),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .upper_levels (upper_levels),
    .codeword_bits(codeword_bits)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial sums_sb = new();

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles, sums_sb.pending());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Sample both handshakes on the edge, before this edge's updates land.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sums_sb.note_path(decision_tree);
      if (out_valid && !out_stall) sums_sb.check_sums(upper_levels, codeword_bits);
    end
  end

  // Receiver: random stall bursts, calm stretches, and one long hold-off on request.
  initial begin
    int calm;
    calm = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
        holds_done++;
      end else if (!quiet) begin
        if (calm > 0) begin
          calm--;
        end else if ($urandom_range(0, 9) == 0) begin
          calm = $urandom_range(20, 60);
        end else if ($urandom_range(0, 4) == 0) begin
          out_stall <= 1'b1;
          repeat ($urandom_range(1, 14)) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  function automatic tree_t level_bits(input int k);
    tree_t m;
    m = '0;
    for (int p = 0; p < (1 << k); p++) m[(1 << k) - 1 + p] = 1'b1;
    return m;
  endfunction

  function automatic tree_t random_tree();
    tree_t t;
    t = tree_t'({$urandom(), $urandom()});
    case ($urandom_range(0, 5))
      0: t = tree_t'(1) << $urandom_range(0, TREE_W - 1);
      1: t = t & level_bits($urandom_range(0, LOG_LEN));
      2: t = ~(tree_t'(1) << $urandom_range(0, TREE_W - 1));
      default: ;
    endcase
    return t;
  endfunction

  // Offer one item and hold it until it is taken.
  task automatic send_path(input tree_t t);
    in_valid      <= 1'b1;
    decision_tree <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic sender_idle(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic maybe_idle();
    if (quiet) return;
    if (sender_calm > 0) begin
      sender_calm--;
    end else if ($urandom_range(0, 11) == 0) begin
      sender_calm = $urandom_range(15, 50);
    end else if ($urandom_range(0, 3) == 0) begin
      sender_idle($urandom_range(1, 14));
    end
  endtask

  // Pause the sender until every expected result is back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sums_sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    tree_t directed[$];
    int    bit_picks[11];
    cycles        = 0;
    hold_req      = 1'b0;
    quiet         = 1'b0;
    holds_done    = 0;
    sender_calm   = 0;
    rst           <= 1'b1;
    in_valid      <= 1'b0;
    decision_tree <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // extremes, alternating patterns, each level alone, level boundaries
    directed.push_back('0);
    directed.push_back('1);
    directed.push_back(tree_t'(64'h5555_5555_5555_5555));
    directed.push_back(tree_t'(64'h2AAA_AAAA_AAAA_AAAA));
    for (int k = 0; k <= LOG_LEN; k++) directed.push_back(level_bits(k));
    bit_picks = '{0, 1, 2, 3, 6, 7, 14, 15, 30, 31, 62};
    foreach (bit_picks[i]) directed.push_back(tree_t'(1) << bit_picks[i]);
    foreach (directed[i]) begin
      send_path(directed[i]);
      maybe_idle();
    end
    drain_results();

    // long receiver hold-off while the sender keeps offering back to back
    hold_req = 1'b1;
    repeat (40) send_path(random_tree());
    drain_results();

    for (int i = 0; i < 740; i++) begin
      if (i == 600) quiet = 1'b1;
      if (i == 300) drain_results();
      send_path(random_tree());
      maybe_idle();
    end
    in_valid <= 1'b0;

    while (sums_sb.pending() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
    if (sums_sb.pending() != 0)
      sums_sb.report_mismatch($sformatf("%0d results never arrived", sums_sb.pending()));

    $display("Encoded %0d path trees (directed extremes, levels, single bits, random)",
             sums_sb.paths_in);
    $display("Checked %0d results across stalls, %0d long hold-off(s), %0d mismatches",
             sums_sb.sums_checked, holds_done, sums_sb.mismatches);
    if (sums_sb.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/ppse_pkg.sv
rtl/polar_partial_sum_encoder_top.sv
dv/ppse_tb_pkg.sv
dv/tb.sv
